// ===== src/bcc_pkg.sv =====
package bcc_pkg;

    localparam int TIMER_WIDTH_DEF = 12;

    localparam int DEB_W = 8;
    localparam int SET_W = 8;
    localparam int LONG_W = 12;
    localparam int DBL_W = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 8'd30;
    localparam logic [SET_W-1:0]  SETTLE_RST   = 8'd50;
    localparam logic [LONG_W-1:0] LONG_RST     = 12'd1000;
    localparam logic [DBL_W-1:0]  DOUBLE_RST   = 12'd700;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_SETTLE   = 2'd1,
        REG_LONG     = 2'd2,
        REG_DOUBLE   = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_IDLE           = 3'd0,
        PH_SETTLE_PRESS   = 3'd1,
        PH_HELD           = 3'd2,
        PH_LONG           = 3'd3,
        PH_SETTLE_RELEASE = 3'd4
    } t_press_phase;

    typedef enum logic [1:0] {
        CLICK_NONE   = 2'd0,
        CLICK_SINGLE = 2'd1,
        CLICK_DOUBLE = 2'd2
    } t_click_kind;

endpackage

// ===== src/button_click_classifier_top.sv =====
// Button click classifier: one raw active-low button sample per tick in,
// one result per tick out (filtered level, long press pulse, click kind).
// Input channel: i_valid / o_stall with payload i_button_raw. A request is
// taken on a rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_button_held, o_long_press_event
// and o_click_kind; a result is taken where o_valid is high and i_stall low.
// A request's result is registered at the edge that takes it. Throughput
// is one request per cycle while o_stall is low, set by the single
// register stage holding the filter, press machine and click timers.
// While the receiver stalls, the output register holds its result and one
// more request is taken into a skid register; o_stall then rises until the
// output register drains. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data, by the user only while the block is idle;
// the block does not enforce this. Synchronous active-low reset restores
// the register defaults (30, 50, 1000, 700), sets the filtered level to
// released, clears all timers, empties both result registers. No clearing pass is needed.
module button_click_classifier_top #(
    parameter int TIMER_WIDTH = bcc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_button_raw,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_button_held,
    output logic                            o_long_press_event,
    output logic [1:0]                      o_click_kind,
    input  logic                            i_cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = (TIMER_WIDTH > bcc_pkg::LONG_W) ? TIMER_WIDTH : bcc_pkg::LONG_W;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    function automatic logic [TIMER_WIDTH-1:0] tick_up(input logic [TIMER_WIDTH-1:0] t);
        return (t == TMAX) ? TMAX : t + 1'b1;
    endfunction

    function automatic logic past(input logic [TIMER_WIDTH-1:0] t, input logic [CW-1:0] thr);
        return (CW'(t) > thr) || (t == TMAX);
    endfunction

    logic [bcc_pkg::DEB_W-1:0]  r_debounce;
    logic [bcc_pkg::SET_W-1:0]  r_settle;
    logic [bcc_pkg::LONG_W-1:0] r_long_ticks;
    logic [bcc_pkg::DBL_W-1:0]  r_double;

    logic                      r_level, n_level;
    logic [TIMER_WIDTH-1:0]    r_since, n_since;
    bcc_pkg::t_press_phase     r_phase, n_phase;
    logic [TIMER_WIDTH-1:0]    r_phase_timer, n_phase_timer;
    logic                      r_long_seen, n_long_seen;
    logic                      r_click_active, n_click_active;
    logic [TIMER_WIDTH-1:0]    r_click_timer, n_click_timer;

    logic                      n_held, n_long_ev;
    bcc_pkg::t_click_kind      n_kind;

    logic                      r_out_valid, r_sk_valid;
    logic                      r_out_held, r_out_long, r_sk_held, r_sk_long;
    bcc_pkg::t_click_kind      r_out_kind, r_sk_kind;

    logic in_acc, out_free;
    logic [TIMER_WIDTH-1:0] cnt, pt_next;
    logic pressed, click;

    assign o_stall  = r_sk_valid;
    assign in_acc   = i_valid && !r_sk_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= bcc_pkg::DEBOUNCE_RST;
            r_settle     <= bcc_pkg::SETTLE_RST;
            r_long_ticks <= bcc_pkg::LONG_RST;
            r_double     <= bcc_pkg::DOUBLE_RST;
        end else if (i_cfg_we) begin
            unique case (bcc_pkg::t_cfg_reg'(i_cfg_index))
                bcc_pkg::REG_DEBOUNCE: r_debounce   <= i_cfg_data[bcc_pkg::DEB_W-1:0];
                bcc_pkg::REG_SETTLE:   r_settle     <= i_cfg_data[bcc_pkg::SET_W-1:0];
                bcc_pkg::REG_LONG:     r_long_ticks <= i_cfg_data[bcc_pkg::LONG_W-1:0];
                bcc_pkg::REG_DOUBLE:   r_double     <= i_cfg_data[bcc_pkg::DBL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // level filter
        cnt = tick_up(r_since);
        n_level = r_level;
        n_since = cnt;
        if ((i_button_raw != r_level) && past(cnt, CW'(r_debounce))) begin
            n_level = i_button_raw;
            n_since = '0;
        end
        pressed = !n_level;

        // press machine
        n_phase       = r_phase;
        n_phase_timer = r_phase_timer;
        n_long_seen   = r_long_seen;
        n_long_ev     = 1'b0;
        click         = 1'b0;
        pt_next       = tick_up(r_phase_timer);
        unique case (r_phase)
            bcc_pkg::PH_IDLE: begin
                if (pressed) begin
                    n_phase       = bcc_pkg::PH_SETTLE_PRESS;
                    n_phase_timer = '0;
                    n_long_seen   = 1'b0;
                end
            end
            bcc_pkg::PH_SETTLE_PRESS: begin
                n_phase_timer = pt_next;
                if (past(pt_next, CW'(r_settle)))
                    n_phase = pressed ? bcc_pkg::PH_HELD : bcc_pkg::PH_IDLE;
            end
            bcc_pkg::PH_HELD: begin
                n_phase_timer = pt_next;
                if (!r_long_seen && past(pt_next, CW'(r_long_ticks))) begin
                    n_long_seen = 1'b1;
                    n_long_ev   = 1'b1;
                    n_phase     = bcc_pkg::PH_LONG;
                end
                if (!pressed) begin
                    n_phase       = bcc_pkg::PH_SETTLE_RELEASE;
                    n_phase_timer = '0;
                end
            end
            bcc_pkg::PH_LONG: begin
                if (!pressed) begin
                    n_phase       = bcc_pkg::PH_SETTLE_RELEASE;
                    n_phase_timer = '0;
                end
            end
            bcc_pkg::PH_SETTLE_RELEASE: begin
                n_phase_timer = pt_next;
                if (past(pt_next, CW'(r_settle))) begin
                    if (!pressed) begin
                        n_phase = bcc_pkg::PH_IDLE;
                        click   = !r_long_seen;
                    end else begin
                        n_phase = bcc_pkg::PH_HELD;
                    end
                end
            end
            default: n_phase = bcc_pkg::PH_IDLE;
        endcase

        // click stage
        n_click_active = r_click_active;
        n_click_timer  = r_click_timer;
        n_kind         = bcc_pkg::CLICK_NONE;
        if (r_click_active) begin
            n_click_timer = tick_up(r_click_timer);
            if (click) begin
                n_kind = (CW'(n_click_timer) < CW'(r_double)) ?
                         bcc_pkg::CLICK_DOUBLE : bcc_pkg::CLICK_SINGLE;
                n_click_active = 1'b0;
            end else if (past(n_click_timer, CW'(r_double))) begin
                n_kind = bcc_pkg::CLICK_SINGLE;
                n_click_active = 1'b0;
            end
        end else if (click) begin
            n_click_active = 1'b1;
            n_click_timer  = '0;
        end

        n_held = pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= 1'b1;
            r_since        <= '0;
            r_phase        <= bcc_pkg::PH_IDLE;
            r_phase_timer  <= '0;
            r_long_seen    <= 1'b0;
            r_click_active <= 1'b0;
            r_click_timer  <= '0;
        end else if (in_acc) begin
            r_level        <= n_level;
            r_since        <= n_since;
            r_phase        <= n_phase;
            r_phase_timer  <= n_phase_timer;
            r_long_seen    <= n_long_seen;
            r_click_active <= n_click_active;
            r_click_timer  <= n_click_timer;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (out_free) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sk_valid) begin
                r_out_held <= r_sk_held;
                r_out_long <= r_sk_long;
                r_out_kind <= r_sk_kind;
            end else if (in_acc) begin
                r_out_held <= n_held;
                r_out_long <= n_long_ev;
                r_out_kind <= n_kind;
            end
        end else if (in_acc) begin
            r_sk_held <= n_held;
            r_sk_long <= n_long_ev;
            r_sk_kind <= n_kind;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_button_held      = r_out_held;
    assign o_long_press_event = r_out_long;
    assign o_click_kind       = r_out_kind;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_stalled_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable({o_button_held, o_long_press_event, o_click_kind})))
        else $error("stalled result changed");

    a_long_phase_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == bcc_pkg::PH_LONG) |-> r_long_seen)
        else $error("long phase without long_seen");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_valid && !$past(i_cfg_we)) |=> $stable(r_phase) || !$past(r_sk_valid))
        else $error("press state advanced while input stalled");

endmodule
